>>> src/icdf_pkg.sv
// Package for the inverse-CDF sampler: sizes, tdata field layout, item kinds,
// controller states, datapath operations and the status struct.
// No dependencies; every other file of the block except icdf_ram imports it.
package icdf_pkg;

  // Table sizes
  localparam int MAX_GRID = 64;
  localparam int MAX_ROW  = 256;
  localparam int GRID_AW  = $clog2(MAX_GRID);
  localparam int ROW_AW   = $clog2(MAX_ROW);
  localparam int TAB_AW   = GRID_AW + ROW_AW;
  localparam int CNT_W    = $clog2((MAX_ROW > MAX_GRID ? MAX_ROW : MAX_GRID) + 1);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int ROW_FW   = 6;
  localparam int COL_FW   = 8;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 9;
  localparam int CDF_W    = 25;
  localparam int U_W      = 24;
  localparam int GP_W     = 7;
  localparam int WEIGHT_W = 25;
  localparam int DIV_CW   = $clog2(WEIGHT_W);
  localparam int TAB_W    = CDF_W + 2 * VAL_W;
  localparam int PROD_W   = VAL_W + 1 + WEIGHT_W + 1;
  localparam int CDF_TOL  = 1;

  // Input tdata layout, lowest bit first
  localparam int F_ROW  = 0;
  localparam int F_COL  = F_ROW + ROW_FW;
  localparam int F_GRID = F_COL + COL_FW;
  localparam int F_LEN  = F_GRID + VAL_W;
  localparam int F_CDF  = F_LEN + LEN_W;
  localparam int F_EXIT = F_CDF + CDF_W;
  localparam int F_R    = F_EXIT + VAL_W;
  localparam int F_Q    = F_R + VAL_W;
  localparam int F_U    = F_Q + VAL_W;
  localparam int IN_W   = F_U + U_W;
  localparam int OUT_W  = 2 * VAL_W;

  // Request kinds carried in tuser
  localparam logic [KIND_W-1:0] KIND_GRID   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_G_PROBE, ST_G_CMP, ST_G_RD1, ST_G_RD2, ST_G_DIV, ST_G_DIVW,
    ST_R_LEN, ST_R_LENW, ST_R_PROBE, ST_R_CMP, ST_R_RD1, ST_R_TAKE0, ST_R_RD2,
    ST_R_DIV, ST_R_DIVW, ST_R_MULE, ST_R_ADDE, ST_R_MULR, ST_R_ADDR, ST_R_END,
    ST_F_MULE, ST_F_ADDE, ST_F_MULR, ST_F_ADDR, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_WRITE, OP_LOAD,
    OP_G_PROBE, OP_G_CMP, OP_G_PICK, OP_G_RD1, OP_G_RD2, OP_G_DIVGO, OP_G_WCAP,
    OP_R_LEN, OP_R_LENW, OP_R_PROBE, OP_R_CMP, OP_R_RD0, OP_R_RD1, OP_R_RD2,
    OP_R_TAKE0, OP_R_TAKE1, OP_R_DIVGO, OP_R_WCAP,
    OP_MUL_RE, OP_ADD_RE, OP_MUL_RR, OP_ADD_RR,
    OP_MUL_FE, OP_ADD_FE, OP_MUL_FR, OP_ADD_FR,
    OP_ROW_B, OP_OUT
  } op_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic g_inside;
    logic g_rising;
    logic k_single;
    logic interp;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/icdf_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module icdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first port; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/icdf_div.sv
// Restoring divider for Q1.24 weights: floor(num * 2^24 / den), one bit a cycle.
// Depends on icdf_pkg. Requires num <= den, which keeps the quotient in 25 bits.
module icdf_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [icdf_pkg::VAL_W-1:0]      num,
  input  logic [icdf_pkg::VAL_W-1:0]      den,
  output logic                            done,
  output logic [icdf_pkg::WEIGHT_W-1:0]   quo
);
  import icdf_pkg::*;

  logic [VAL_W:0]    rem;
  logic [VAL_W-1:0]  dreg;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic              ge;
  logic [VAL_W:0]    diff;

  // One quotient bit per step, most significant first.
  always_comb begin
    ge   = rem >= {1'b0, dreg};
    diff = ge ? rem - {1'b0, dreg} : rem;
  end

  // Busy flag and a one-cycle done pulse after the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      dreg <= den;
      cnt  <= DIV_CW'(WEIGHT_W - 1);
      quo  <= '0;
    end else if (busy) begin
      rem <= {diff[VAL_W-1:0], 1'b0};
      quo <= {quo[WEIGHT_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

>>> src/icdf_ctrl.sv
// Controller state machine: sequences the grid search, the row searches, the
// divisions and the blends. Depends on icdf_pkg.
module icdf_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [icdf_pkg::KIND_W-1:0]     in_kind,
  output logic                            in_ready,
  input  icdf_pkg::dp_status_t            status,
  output icdf_pkg::op_t                   op
);
  import icdf_pkg::*;

  state_t state, state_next;
  logic   pass_b;
  logic   do_blend;

  // State register and the flags for the second row pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pass_b   <= 1'b0;
      do_blend <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_LOAD) begin
        pass_b   <= 1'b0;
        do_blend <= 1'b0;
      end
      if (state == ST_G_DIV) begin
        do_blend <= status.g_rising;
      end
      if (op == OP_ROW_B) begin
        pass_b <= 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid && in_kind == KIND_SAMPLE) state_next = ST_G_PROBE;
      ST_G_PROBE: begin
        if (status.lo_lt_hi) state_next = ST_G_CMP;
        else if (status.g_inside) state_next = ST_G_RD1;
        else state_next = ST_R_LEN;
      end
      ST_G_CMP:   state_next = ST_G_PROBE;
      ST_G_RD1:   state_next = ST_G_RD2;
      ST_G_RD2:   state_next = ST_G_DIV;
      ST_G_DIV:   state_next = status.g_rising ? ST_G_DIVW : ST_R_LEN;
      ST_G_DIVW:  if (status.div_done) state_next = ST_R_LEN;
      ST_R_LEN:   state_next = ST_R_LENW;
      ST_R_LENW:  state_next = ST_R_PROBE;
      ST_R_PROBE: state_next = status.lo_lt_hi ? ST_R_CMP : ST_R_RD1;
      ST_R_CMP:   state_next = ST_R_PROBE;
      ST_R_RD1:   state_next = status.k_single ? ST_R_TAKE0 : ST_R_RD2;
      ST_R_TAKE0: state_next = ST_R_END;
      ST_R_RD2:   state_next = ST_R_DIV;
      ST_R_DIV:   state_next = status.interp ? ST_R_DIVW : ST_R_END;
      ST_R_DIVW:  if (status.div_done) state_next = ST_R_MULE;
      ST_R_MULE:  state_next = ST_R_ADDE;
      ST_R_ADDE:  state_next = ST_R_MULR;
      ST_R_MULR:  state_next = ST_R_ADDR;
      ST_R_ADDR:  state_next = ST_R_END;
      ST_R_END: begin
        if (pass_b) state_next = ST_F_MULE;
        else if (do_blend) state_next = ST_R_LEN;
        else state_next = ST_OUT;
      end
      ST_F_MULE:  state_next = ST_F_ADDE;
      ST_F_ADDE:  state_next = ST_F_MULR;
      ST_F_MULR:  state_next = ST_F_ADDR;
      ST_F_ADDR:  state_next = ST_OUT;
      ST_OUT:     if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Datapath operation for each state.
  always_comb begin
    op       = OP_NOP;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = (in_kind == KIND_SAMPLE) ? OP_LOAD : OP_WRITE;
      end
      ST_G_PROBE: op = status.lo_lt_hi ? OP_G_PROBE : OP_G_PICK;
      ST_G_CMP:   op = OP_G_CMP;
      ST_G_RD1:   op = OP_G_RD1;
      ST_G_RD2:   op = OP_G_RD2;
      ST_G_DIV:   if (status.g_rising) op = OP_G_DIVGO;
      ST_G_DIVW:  if (status.div_done) op = OP_G_WCAP;
      ST_R_LEN:   op = OP_R_LEN;
      ST_R_LENW:  op = OP_R_LENW;
      ST_R_PROBE: op = status.lo_lt_hi ? OP_R_PROBE : OP_R_RD0;
      ST_R_CMP:   op = OP_R_CMP;
      ST_R_RD1:   op = OP_R_RD1;
      ST_R_TAKE0: op = OP_R_TAKE0;
      ST_R_RD2:   op = OP_R_RD2;
      ST_R_DIV:   op = status.interp ? OP_R_DIVGO : OP_R_TAKE1;
      ST_R_DIVW:  if (status.div_done) op = OP_R_WCAP;
      ST_R_MULE:  op = OP_MUL_RE;
      ST_R_ADDE:  op = OP_ADD_RE;
      ST_R_MULR:  op = OP_MUL_RR;
      ST_R_ADDR:  op = OP_ADD_RR;
      ST_R_END:   if (!pass_b && do_blend) op = OP_ROW_B;
      ST_F_MULE:  op = OP_MUL_FE;
      ST_F_ADDE:  op = OP_ADD_FE;
      ST_F_MULR:  op = OP_MUL_FR;
      ST_F_ADDR:  op = OP_ADD_FR;
      ST_OUT:     if (status.out_free) op = OP_OUT;
      default:    op = OP_NOP;
    endcase
  end

endmodule

>>> src/icdf_dp.sv
// Datapath: table memories, search registers, the weight divider, the shared
// blend multiplier and the output register. Depends on icdf_pkg, icdf_ram, icdf_div.
module icdf_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  icdf_pkg::op_t                   op,
  output icdf_pkg::dp_status_t            status,
  input  logic [icdf_pkg::IN_W-1:0]       in_data,
  input  logic [icdf_pkg::KIND_W-1:0]     in_kind,
  input  logic                            cfg_we,
  input  logic [icdf_pkg::GP_W-1:0]       cfg_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [icdf_pkg::OUT_W-1:0]      out_data
);
  import icdf_pkg::*;

  // Request fields
  logic [ROW_FW-1:0] f_row;
  logic [COL_FW-1:0] f_col;
  logic [VAL_W-1:0]  f_grid, f_exit, f_r, f_q;
  logic [LEN_W-1:0]  f_len;
  logic [CDF_W-1:0]  f_cdf;
  logic [U_W-1:0]    f_u;

  assign f_row  = in_data[F_ROW  +: ROW_FW];
  assign f_col  = in_data[F_COL  +: COL_FW];
  assign f_grid = in_data[F_GRID +: VAL_W];
  assign f_len  = in_data[F_LEN  +: LEN_W];
  assign f_cdf  = in_data[F_CDF  +: CDF_W];
  assign f_exit = in_data[F_EXIT +: VAL_W];
  assign f_r    = in_data[F_R    +: VAL_W];
  assign f_q    = in_data[F_Q    +: VAL_W];
  assign f_u    = in_data[F_U    +: U_W];

  logic [GP_W-1:0]    grid_points;
  logic [VAL_W-1:0]   q, g0, g1;
  logic [U_W-1:0]     u;
  logic [CNT_W-1:0]   n, lo, hi, mid, len;
  logic [GRID_AW-1:0] cur_row;
  logic [CDF_W-1:0]   c0, c1;
  logic [VAL_W-1:0]   e0, r0, e1, r1, re, rr, ae, ar;
  logic [WEIGHT_W-1:0] wg, wr;
  logic signed [PROD_W-1:0] prod;

  // Combinational helpers
  logic [CNT_W:0]     lohi_sum;
  logic [CNT_W-1:0]   mid_probe, lo_m1, mid_p1, n_clamp, len_clamp, n_m1;
  logic [GRID_AW-1:0] grid_addr, len_addr;
  logic [TAB_AW-1:0]  tab_addr;
  logic               grid_we, len_we, tab_we;
  logic [VAL_W-1:0]   grid_q;
  logic [LEN_W-1:0]   len_q;
  logic [TAB_W-1:0]   tab_q;
  logic [CDF_W-1:0]   tab_cdf, cdf_step, u_ext;
  logic [VAL_W-1:0]   tab_e, tab_r;

  assign lohi_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_probe = lohi_sum[CNT_W:1];
  assign lo_m1     = lo - 1'b1;
  assign mid_p1    = mid + 1'b1;
  assign n_m1      = n - 1'b1;
  assign u_ext     = {{(CDF_W - U_W){1'b0}}, u};
  assign tab_cdf   = tab_q[CDF_W-1:0];
  assign tab_e     = tab_q[CDF_W +: VAL_W];
  assign tab_r     = tab_q[CDF_W + VAL_W +: VAL_W];
  assign cdf_step  = c1 - c0;

  // Grid count 0 acts as 1, counts above the grid size as the grid size.
  always_comb begin
    if (grid_points == '0) n_clamp = CNT_W'(1);
    else if (grid_points > GP_W'(MAX_GRID)) n_clamp = CNT_W'(MAX_GRID);
    else n_clamp = CNT_W'(grid_points);
  end

  // Row length 0 acts as 1, lengths above the row size as the row size.
  always_comb begin
    if (len_q == '0) len_clamp = CNT_W'(1);
    else if (len_q > LEN_W'(MAX_ROW)) len_clamp = CNT_W'(MAX_ROW);
    else len_clamp = CNT_W'(len_q);
  end

  // Memory address selection; writes arrive only while idle.
  assign grid_we  = (op == OP_WRITE) && (in_kind == KIND_GRID);
  assign len_we   = (op == OP_WRITE) && (in_kind == KIND_LEN);
  assign tab_we   = (op == OP_WRITE) && (in_kind == KIND_ENTRY);
  assign len_addr = len_we ? f_row : cur_row;

  always_comb begin
    case (op)
      OP_WRITE:   grid_addr = f_row;
      OP_G_PROBE: grid_addr = mid_probe[GRID_AW-1:0];
      OP_G_PICK:  grid_addr = lo_m1[GRID_AW-1:0];
      default:    grid_addr = lo[GRID_AW-1:0];
    endcase
  end

  always_comb begin
    case (op)
      OP_WRITE:   tab_addr = {f_row, f_col};
      OP_R_PROBE: tab_addr = {cur_row, mid_probe[ROW_AW-1:0]};
      OP_R_RD0:   tab_addr = {cur_row, (lo == '0) ? ROW_AW'(0) : lo_m1[ROW_AW-1:0]};
      default:    tab_addr = {cur_row, lo[ROW_AW-1:0]};
    endcase
  end

  icdf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_GRID)) u_grid_ram (
    .clk(clk), .we(grid_we), .addr(grid_addr), .wdata(f_grid), .rdata(grid_q)
  );

  icdf_ram #(.WIDTH(LEN_W), .DEPTH(MAX_GRID)) u_len_ram (
    .clk(clk), .we(len_we), .addr(len_addr), .wdata(f_len), .rdata(len_q)
  );

  icdf_ram #(.WIDTH(TAB_W), .DEPTH(MAX_GRID * MAX_ROW)) u_tab_ram (
    .clk(clk), .we(tab_we), .addr(tab_addr), .wdata({f_r, f_exit, f_cdf}), .rdata(tab_q)
  );

  // Weight divider, shared by the grid and the row interpolations.
  logic                div_start, div_done;
  logic [VAL_W-1:0]    div_num, div_den;
  logic [WEIGHT_W-1:0] div_quo;

  assign div_start = (op == OP_G_DIVGO) || (op == OP_R_DIVGO);
  assign div_num   = (op == OP_G_DIVGO) ? q - g0 : VAL_W'(u_ext - c0);
  assign div_den   = (op == OP_G_DIVGO) ? g1 - g0 : VAL_W'(cdf_step);

  icdf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // Blend: lo + floor(((hi - lo) * w + 2^23) / 2^24), multiply then add.
  logic [VAL_W-1:0]         bl_lo, bl_hi, bl_res;
  logic [WEIGHT_W-1:0]      bl_w;
  logic signed [VAL_W:0]    bl_d;
  logic signed [PROD_W-1:0] bl_prod, bl_sum;

  always_comb begin
    case (op)
      OP_MUL_RR, OP_ADD_RR: begin
        bl_lo = r0; bl_hi = r1; bl_w = wr;
      end
      OP_MUL_FE, OP_ADD_FE: begin
        bl_lo = re; bl_hi = ae; bl_w = wg;
      end
      OP_MUL_FR, OP_ADD_FR: begin
        bl_lo = rr; bl_hi = ar; bl_w = wg;
      end
      default: begin
        bl_lo = e0; bl_hi = e1; bl_w = wr;
      end
    endcase
  end

  assign bl_d    = $signed({bl_hi[VAL_W-1], bl_hi}) - $signed({bl_lo[VAL_W-1], bl_lo});
  assign bl_prod = bl_d * $signed({1'b0, bl_w});
  assign bl_sum  = prod + (PROD_W'(1) <<< (WEIGHT_W - 2));
  assign bl_res  = bl_lo + bl_sum[WEIGHT_W-1 +: VAL_W];

  // Grid count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_points <= GP_W'(1);
    end else if (cfg_we) begin
      grid_points <= cfg_value;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        q  <= f_q;
        u  <= f_u;
        n  <= n_clamp;
        lo <= '0;
        hi <= n_clamp;
      end
      OP_G_PROBE, OP_R_PROBE: mid <= mid_probe;
      OP_G_CMP: begin
        if (grid_q < q) lo <= mid_p1;
        else hi <= mid;
      end
      OP_G_PICK: begin
        if (lo == '0) cur_row <= '0;
        else if (lo == n) cur_row <= n_m1[GRID_AW-1:0];
        else cur_row <= lo[GRID_AW-1:0];
      end
      OP_G_RD1:  g0 <= grid_q;
      OP_G_RD2:  g1 <= grid_q;
      OP_G_WCAP: wg <= div_quo;
      OP_R_LENW: begin
        lo  <= '0;
        hi  <= len_clamp;
        len <= len_clamp;
      end
      OP_R_CMP: begin
        if (tab_cdf < u_ext) lo <= mid_p1;
        else hi <= mid;
      end
      OP_R_RD1: begin
        c0 <= tab_cdf; e0 <= tab_e; r0 <= tab_r;
      end
      OP_R_RD2: begin
        c1 <= tab_cdf; e1 <= tab_e; r1 <= tab_r;
      end
      OP_R_WCAP:  wr <= div_quo;
      OP_R_TAKE0: begin
        re <= e0; rr <= r0;
      end
      OP_R_TAKE1: begin
        re <= e1; rr <= r1;
      end
      OP_MUL_RE, OP_MUL_RR, OP_MUL_FE, OP_MUL_FR: prod <= bl_prod;
      OP_ADD_RE, OP_ADD_FE: re <= bl_res;
      OP_ADD_RR, OP_ADD_FR: rr <= bl_res;
      OP_ROW_B: begin
        ae      <= re;
        ar      <= rr;
        cur_row <= cur_row - 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      out_data <= {rr, re};
    end
  end

  // Status toward the controller.
  always_comb begin
    status.lo_lt_hi = lo < hi;
    status.g_inside = (lo != '0) && (lo != n);
    status.g_rising = g1 > g0;
    status.k_single = (lo == '0) || (lo == len);
    status.interp   = (c1 > c0) && (cdf_step > CDF_W'(CDF_TOL));
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
  end

endmodule

>>> src/inverse_cdf_sample_energy_r.sv
// Top level of the inverse-CDF sampler: controller plus datapath.
// Depends on icdf_pkg, icdf_ctrl, icdf_dp (and through it icdf_ram, icdf_div).
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------
//   s_axis   | s_axis_tvalid/s_axis_tready | tdata 200 b, tuser = kind
//   m_axis   | m_axis_tvalid/m_axis_tready | tdata 64 b: out_energy, out_r
//   cfg      | cfg_valid/cfg_ready         | cfg_data = grid_points
//
// A write request is stored when it is accepted and leaves the input open. A
// sample request spends a probe and a compare per binary-search step, a weight
// division per interpolation (start, 25 quotient bits in the shared divider,
// capture) and a multiply and an add per blend of energy and r, for one row or
// two blended rows; the input opens once the result is loaded for output.
// Synchronous active-high reset; it sets grid_points to 1, the tables stay
// undefined until written. A waiting result blocks only the next result.
module inverse_cdf_sample_energy_r (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // row, column, grid_energy, row_points, cdf_point, exit_energy_point,
  // r_point, query_energy, uniform (lowest bits first)
  input  logic [icdf_pkg::IN_W-1:0]     s_axis_tdata,
  // kind
  input  logic [icdf_pkg::KIND_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_energy, out_r (lowest bits first)
  output logic [icdf_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [icdf_pkg::GP_W-1:0]     cfg_data
);
  import icdf_pkg::*;

  op_t        op;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  icdf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_kind(s_axis_tuser),
    .in_ready(s_axis_tready), .status(status), .op(op)
  );

  icdf_dp u_dp (
    .clk(clk), .rst(rst), .op(op), .status(status),
    .in_data(s_axis_tdata), .in_kind(s_axis_tuser),
    .cfg_we(cfg_valid && cfg_ready), .cfg_value(cfg_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

  // A sample request closes the input until its result is out.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_SAMPLE) |=> !s_axis_tready)
    else $error("input still open after a sample request");

  // A result only appears through the output load operation.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(op == OP_OUT))
    else $error("result valid without an output load");

  // The output load never overwrites a result that was not taken.
  assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output overwritten while stalled");

endmodule

>>> sim/inverse_cdf_sample_energy_r_tb.sv
// Self-checking testbench for the inverse-CDF sampler with bilinear blending.
// Depends on icdf_pkg and inverse_cdf_sample_energy_r; predicts every sample
// result from its own table copy and checks it under random flow control.
module inverse_cdf_sample_energy_r_tb;
  import icdf_pkg::*;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] column;
    logic [31:0]       grid_energy;
    logic [LEN_W-1:0]  row_points;
    logic [CDF_W-1:0]  cdf_point;
    logic [31:0]       exit_point;
    logic [31:0]       r_point;
    logic [31:0]       query;
    logic [U_W-1:0]    uniform;
  } request_t;

  typedef struct {
    logic signed [31:0] energy;
    logic signed [31:0] r;
  } sample_t;

  localparam longint ONE = 64'd16777216;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic [KIND_W-1:0]  s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [GP_W-1:0]    cfg_data = '0;

  // Predictor state: a private copy of the tables and the register.
  logic [31:0]        grid_copy [MAX_GRID];
  logic [LEN_W-1:0]   len_copy [MAX_GRID];
  logic [CDF_W-1:0]   cdf_copy [MAX_GRID*MAX_ROW];
  logic signed [31:0] exit_copy [MAX_GRID*MAX_ROW];
  logic signed [31:0] r_copy [MAX_GRID*MAX_ROW];
  logic [GP_W-1:0]    grid_points_copy;
  // Entries written so far per row, from column 0 up, to keep reads defined.
  int                 entries_written [MAX_GRID];

  sample_t pending_samples [$];
  int      mismatch_count = 0;
  bit      quiet = 1'b0;
  bit      hold_out = 1'b0;
  int      out_stall = 0;

  inverse_cdf_sample_energy_r DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Limit on the whole run.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  // Q1.24 weight of num over den, clamped to one.
  function automatic longint weight_of(longint num, longint den);
    longint w;
    if (den == 0) return ONE;
    w = (num <<< 24) / den;
    return (w > ONE) ? ONE : w;
  endfunction

  // Linear blend with round half up; the arithmetic shift floors.
  function automatic longint mix(longint lo, longint hi, longint w);
    longint acc;
    acc = hi * w + lo * (ONE - w) + (ONE / 2);
    return acc >>> 24;
  endfunction

  // Inverse-CDF lookup within one row.
  task automatic row_lookup(input int rw, input logic [U_W-1:0] u,
                            output longint e, output longint rv);
    int len, base, lo, hi, mid, k;
    longint c0, c1, w;
    len = len_copy[rw];
    if (len < 1) len = 1;
    if (len > MAX_ROW) len = MAX_ROW;
    base = rw * MAX_ROW;
    lo = 0;
    hi = len;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (cdf_copy[base+mid] < u) lo = mid + 1;
      else hi = mid;
    end
    k = lo;
    if (k == 0) begin
      e = exit_copy[base];
      rv = r_copy[base];
    end else if (k == len) begin
      e = exit_copy[base+len-1];
      rv = r_copy[base+len-1];
    end else begin
      c0 = cdf_copy[base+k-1];
      c1 = cdf_copy[base+k];
      if (c1 > c0 && c1 - c0 > CDF_TOL) begin
        w = weight_of(longint'(u) - c0, c1 - c0);
        e = mix(exit_copy[base+k-1], exit_copy[base+k], w);
        rv = mix(r_copy[base+k-1], r_copy[base+k], w);
      end else begin
        e = exit_copy[base+k];
        rv = r_copy[base+k];
      end
    end
  endtask

  // Expected result of one sample request.
  task automatic predict_sample(input request_t q);
    int n, lo, hi, mid;
    longint ea, ra, eb, rb, g0, g1, w;
    sample_t s;
    n = grid_points_copy;
    if (n < 1) n = 1;
    if (n > MAX_GRID) n = MAX_GRID;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (grid_copy[mid] < q.query) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) begin
      row_lookup(0, q.uniform, ea, ra);
    end else if (lo == n) begin
      row_lookup(n - 1, q.uniform, ea, ra);
    end else begin
      g0 = grid_copy[lo-1];
      g1 = grid_copy[lo];
      row_lookup(lo, q.uniform, ea, ra);
      if (g1 > g0) begin
        w = weight_of(longint'(q.query) - g0, g1 - g0);
        row_lookup(lo - 1, q.uniform, eb, rb);
        ea = mix(eb, ea, w);
        ra = mix(rb, ra, w);
      end
    end
    s.energy = ea[31:0];
    s.r = ra[31:0];
    pending_samples = {pending_samples, s};
  endtask

  // Update the copy once a request is accepted.
  task automatic apply_request(input request_t q);
    int a;
    a = q.row * MAX_ROW + q.column;
    case (q.kind)
      KIND_GRID:   grid_copy[q.row] = q.grid_energy;
      KIND_LEN:    len_copy[q.row] = q.row_points;
      KIND_ENTRY: begin
        cdf_copy[a] = q.cdf_point;
        exit_copy[a] = q.exit_point;
        r_copy[a] = q.r_point;
      end
      default:     predict_sample(q);
    endcase
  endtask

  function automatic request_t random_request(logic [KIND_W-1:0] kind);
    request_t q;
    q.kind = kind;
    q.row = ROW_FW'($urandom);
    q.column = COL_FW'($urandom);
    q.grid_energy = $urandom;
    q.row_points = LEN_W'($urandom);
    q.cdf_point = CDF_W'($urandom);
    q.exit_point = $urandom;
    q.r_point = $urandom;
    q.query = $urandom;
    q.uniform = U_W'($urandom);
    return q;
  endfunction

  // Offer one request, wait for acceptance, then maybe leave a gap.
  task automatic send_request(input request_t q);
    logic [IN_W-1:0] d;
    d = '0;
    d[F_ROW +: ROW_FW] = q.row;
    d[F_COL +: COL_FW] = q.column;
    d[F_GRID +: VAL_W] = q.grid_energy;
    d[F_LEN +: LEN_W] = q.row_points;
    d[F_CDF +: CDF_W] = q.cdf_point;
    d[F_EXIT +: VAL_W] = q.exit_point;
    d[F_R +: VAL_W] = q.r_point;
    d[F_Q +: VAL_W] = q.query;
    d[F_U +: U_W] = q.uniform;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= q.kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_request(q);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_grid(input int rw, input logic [31:0] v);
    request_t q;
    q = random_request(KIND_GRID);
    q.row = ROW_FW'(rw);
    q.grid_energy = v;
    send_request(q);
  endtask

  task automatic write_length(input int rw, input int len);
    request_t q;
    q = random_request(KIND_LEN);
    q.row = ROW_FW'(rw);
    q.row_points = LEN_W'(len);
    send_request(q);
  endtask

  task automatic write_entry(input int rw, input int col, input longint c);
    request_t q;
    q = random_request(KIND_ENTRY);
    q.row = ROW_FW'(rw);
    q.column = COL_FW'(col);
    q.cdf_point = CDF_W'(c);
    send_request(q);
    if (col == entries_written[rw]) entries_written[rw]++;
  endtask

  task automatic sample(input int unsigned qe, input int unsigned u);
    request_t q;
    q = random_request(KIND_SAMPLE);
    q.query = qe;
    q.uniform = U_W'(u);
    send_request(q);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  // Register write while the block is idle; writes leave no result behind,
  // so a pause covering the longest sample follows the drain.
  task automatic set_grid_points(input int v);
    drain();
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= GP_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grid_points_copy = GP_W'(v);
    cfg_valid <= 1'b0;
  endtask

  // Ascending CDF row with unit steps, repeats and a top value of one.
  task automatic fill_row(input int rw, input int count);
    int c;
    c = $urandom_range(0, 1000);
    for (int i = 0; i < count; i++) begin
      write_entry(rw, i, c);
      case ($urandom_range(0, 5))
        0: c = c + 1;
        1: c = c;
        default: c = c + $urandom_range(2, 2 * int'(ONE) / count);
      endcase
      if (c > ONE) c = int'(ONE);
      if (i == count - 2 && $urandom_range(0, 1) == 0) c = int'(ONE);
    end
  endtask

  task automatic load_tables;
    for (int i = 0; i < MAX_GRID; i++)
      write_grid(i, (i == 11) ? 32'h2C00_0000 : i * 32'h0400_0000);
    // Row 0 holds hand-picked points for the directed checks.
    write_entry(0, 0, 100);
    write_entry(0, 1, 100);
    write_entry(0, 2, 101);
    write_entry(0, 3, 5000);
    write_entry(0, 4, ONE);
    write_length(0, 5);
    for (int i = 1; i < MAX_GRID; i++) begin
      if (i == 7 || i == 20) fill_row(i, MAX_ROW);
      else fill_row(i, $urandom_range(1, 6));
    end
    for (int i = 1; i < MAX_GRID; i++) begin
      // Length zero and lengths past the table end are clamped by the block.
      if (i == 7) write_length(i, 300);
      else if (i == 9) write_length(i, 0);
      else write_length(i, entries_written[i]);
    end
  endtask

  task automatic test_directed;
    set_grid_points(1);
    sample(0, 50);
    sample(32'hFFFF_FFFF, 100);
    sample(5, 101);
    sample(0, 3000);
    sample(0, 24'hFF_FFFF);
    set_grid_points(0);
    sample(32'h0123_4567, 24'h80_0000);
    set_grid_points(MAX_GRID);
    sample(0, 0);
    sample(32'h0400_0000, 24'h00_0064);
    sample(32'h0600_0000, 24'h40_0000);
    sample(32'h2A00_0000, 24'h12_3456);
    sample(32'h2C00_0000, 24'h65_4321);
    sample(32'h1C01_0000, 24'hFF_FFFF);
    sample(32'hFC00_0000, 24'h00_0001);
    sample(32'hFFFF_FFFF, 24'hAA_AAAA);
    sample(32'h5000_0000, 24'h55_5555);
    set_grid_points(127);
    sample(32'hFFFF_FFFF, 24'h80_0000);
    sample(32'h7FFF_FFFF, 24'h7F_FFFF);
  endtask

  // Mostly samples, half of them near grid points, with table rewrites mixed in.
  task automatic random_phase(input int count);
    int rw, len;
    logic [31:0] qe;
    for (int i = 0; i < count; i++) begin
      rw = $urandom_range(0, MAX_GRID - 1);
      case ($urandom_range(0, 19))
        0: write_grid(rw, ($urandom_range(0, 3) == 0) ? $urandom
                          : rw * 32'h0400_0000 + $urandom_range(0, 32'h03FF_FFFF));
        1: begin
          len = (entries_written[rw] == MAX_ROW) ? $urandom_range(0, 511)
                : $urandom_range(0, entries_written[rw]);
          write_length(rw, len);
        end
        2, 3: write_entry(rw, $urandom_range(0, (entries_written[rw] < MAX_ROW)
                          ? entries_written[rw] : MAX_ROW - 1), $urandom);
        default: begin
          qe = ($urandom_range(0, 1) == 0) ? $urandom
               : grid_copy[rw] + $urandom_range(0, 32'h0500_0000) - 32'h0080_0000;
          sample(qe, $urandom);
        end
      endcase
    end
  endtask

  // The receiver holds off while requests keep coming, then the sender pauses.
  task automatic test_backpressure;
    fork
      begin
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (800) @(posedge clk);
        hold_out <= 1'b0;
      end
      for (int i = 0; i < 30; i++) sample($urandom, $urandom);
    join
    drain();
  endtask

  // Receiver flow control: random stall bursts, and a full hold while hold_out is set.
  always @(posedge clk) begin
    if (hold_out) begin
      m_axis_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expected sample.
  always @(posedge clk) begin
    sample_t s;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result energy %h r %h", m_axis_tdata[31:0], m_axis_tdata[63:32]);
        mismatch_count++;
      end else begin
        s = pending_samples.pop_front();
        if (m_axis_tdata[31:0] !== s.energy) begin
          $error("out_energy expected %h actual %h", s.energy, m_axis_tdata[31:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[63:32] !== s.r) begin
          $error("out_r expected %h actual %h", s.r, m_axis_tdata[63:32]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    grid_points_copy = 1;
    for (int i = 0; i < MAX_GRID; i++) entries_written[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    load_tables();
    test_directed();
    set_grid_points(MAX_GRID);
    random_phase(150);
    test_backpressure();
    set_grid_points($urandom_range(2, 63));
    random_phase(100);
    set_grid_points(127);
    random_phase(80);
    set_grid_points(0);
    random_phase(60);
    set_grid_points(MAX_GRID);
    quiet = 1'b1;
    random_phase(100);
    drain();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_samples.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
src/icdf_pkg.sv
src/icdf_ram.sv
src/icdf_div.sv
src/icdf_ctrl.sv
src/icdf_dp.sv
src/inverse_cdf_sample_energy_r.sv
sim/inverse_cdf_sample_energy_r_tb.sv
